FILE: rtl/cube_map_face_texel_address_defines.svh
`ifndef CUBE_MAP_FACE_TEXEL_ADDRESS_DEFINES_SVH
`define CUBE_MAP_FACE_TEXEL_ADDRESS_DEFINES_SVH

// Check that cons follows ante; both sampled on clk_i, off while in reset.
`define CMFTA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("cmfta port check failed");

// Check that cond holds at every clock edge out of reset.
`define CMFTA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("cmfta port check failed");

`endif

FILE: rtl/cmfta_pkg.sv
`default_nettype none

package cmfta_pkg;

  // Configuration register data width and index width
  localparam int CFG_W  = 12;
  localparam int CFG_AW = 1;

  // Face code width
  localparam int FACE_W = 3;

  // Defaults for the top level parameters
  localparam int DEF_MAX_FACE_SIZE   = 2048;
  localparam int DEF_COMPONENT_WIDTH = 16;

  // Reset value of both size registers
  localparam logic [CFG_W-1:0] SIZE_RESET = 12'd256;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FACE_WIDTH  = 1'b0,
    CFG_FACE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  // Bits of a texel coordinate: coordinates run 0 .. max_size-1
  function automatic int cmfta_tex_width(input int max_size);
    int w;
    w = $clog2(max_size);
    return (w < 1) ? 1 : w;
  endfunction

  // Bits of a saturated size value: 0 .. max_size
  function automatic int cmfta_size_width(input int max_size);
    return $clog2(max_size + 1);
  endfunction

  // Cycles from start to done_o: four front stages, one divider stage per
  // quotient bit, one output stage
  function automatic int cmfta_latency(input int max_size);
    return cmfta_tex_width(max_size) + 5;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cmfta_div.sv
`default_nettype none

// Pipelined restoring divider: one quotient bit per register stage.
// The quotient must fit in QUO_W bits, i.e. num_i < den_i * 2**QUO_W.
module cmfta_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 17,
  parameter int QUO_W = 11
) (
  input  wire logic             clk_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o
);

  // Partial remainder, low dividend bits shifting out / quotient bits in
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] lq_q  [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] lq_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [QUO_W:0]   shifted;

    // Pick up the previous stage, or split the dividend at the first one
    if (k == 0) begin : g_first
      assign rem_in = num_i[QUO_W+DEN_W-1:QUO_W];
      assign lq_in  = num_i[QUO_W-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lq_in  = lq_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Shift in the next dividend bit, try the subtract
    always_comb begin
      trial   = {rem_in, lq_in[QUO_W-1]};
      diff    = trial - {1'b0, den_in};
      ge      = (trial >= {1'b0, den_in});
      shifted = {lq_in, ge};
    end

    // Advance one stage
    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lq_q[k]  <= shifted[QUO_W-1:0];
      den_q[k] <= den_in;
    end
  end

  assign quo_o = lq_q[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/cube_map_face_texel_address.sv
// Cube map face and texel address unit. Each start cycle takes one signed
// direction (dir_x_i, dir_y_i, dir_z_i) and, after the front stages, the
// divider and the output stage, shows face, texel coordinates, linear
// texel index and valid_res on the result ports for the single cycle that
// done_o is high. A new direction may be started in every cycle; busy is
// never raised. Most of the latency is the restoring divider that forms
// floor(u * size), one quotient bit per pipeline stage. The receiver
// cannot stall: each result must be taken in its done_o cycle. Face sizes
// above MAX_FACE_SIZE are used as MAX_FACE_SIZE. Write the size registers
// only while no item is in flight.
`default_nettype none

module cube_map_face_texel_address
  import cmfta_pkg::*;
#(
  parameter int MAX_FACE_SIZE   = DEF_MAX_FACE_SIZE,
  parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH,
  localparam int TW = cmfta_tex_width(MAX_FACE_SIZE),
  localparam int IW = 2 * TW
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_x_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_y_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_z_i,
  input  wire logic                              cfg_we_i,
  input  wire logic        [CFG_AW-1:0]          cfg_addr_i,
  input  wire logic        [CFG_W-1:0]           cfg_wdata_i,
  output logic                                   done_o,
  output logic             [FACE_W-1:0]          face_o,
  output logic             [TW-1:0]              texel_x_o,
  output logic             [TW-1:0]              texel_y_o,
  output logic             [IW-1:0]              texel_index_o,
  output logic                                   valid_res_o
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int SW   = cmfta_size_width(MAX_FACE_SIZE);
  localparam int DW   = CW + 1;
  localparam int NW   = CW + 1 + SW;
  localparam int PW   = CW + 11;
  localparam int SATW = (SW > CFG_W) ? SW : CFG_W;
  localparam int XW   = TW + SW + 1;

  typedef struct packed {
    logic            vres;
    face_e           face;
    logic [SW-1:0]   ws;
  } side_t;

  // ---------------------------------------------------------------------
  // Size registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_FACE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_FACE_HEIGHT: height_q <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // Full rate pipeline, never holds off a transfer
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: magnitudes and largest magnitude
  // ---------------------------------------------------------------------
  logic [CW-1:0] ax, ay, az, axy, amax;

  always_comb begin
    ax   = dir_x_i[CW-1] ? (CW'(~dir_x_i) + CW'(1)) : CW'(dir_x_i);
    ay   = dir_y_i[CW-1] ? (CW'(~dir_y_i) + CW'(1)) : CW'(dir_y_i);
    az   = dir_z_i[CW-1] ? (CW'(~dir_z_i) + CW'(1)) : CW'(dir_z_i);
    axy  = (ax > ay) ? ax : ay;
    amax = (axy > az) ? axy : az;
  end

  logic                 s1_vld_q;
  logic signed [CW-1:0] s1_comp_q [3];
  logic [CW-1:0]        s1_a_q;

  always_ff @(posedge clk_i) begin
    s1_comp_q[0] <= dir_x_i;
    s1_comp_q[1] <= dir_y_i;
    s1_comp_q[2] <= dir_z_i;
    s1_a_q       <= amax;
  end

  // ---------------------------------------------------------------------
  // Stage 2: ratio tests and face pick, last passing face wins
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] ma;
  logic signed [PW-1:0] pc [3];
  logic [2:0]           pos, neg;
  face_e                face_d;
  logic signed [CW-1:0] cu_d, cv_d;
  logic                 un_d, vn_d;

  always_comb begin
    ma = $signed(PW'(s1_a_q)) * PW'(999);
    for (int i = 0; i < 3; i++) begin
      pc[i]  = PW'(s1_comp_q[i]) * PW'(1000);
      pos[i] = (pc[i] > ma);
      neg[i] = (pc[i] < -ma);
    end

    face_d = FACE_POS_X;
    cu_d   = s1_comp_q[0];
    cv_d   = s1_comp_q[1];
    un_d   = 1'b0;
    vn_d   = 1'b0;
    priority if (pos[2]) begin
      face_d = FACE_POS_Z;
    end else if (neg[2]) begin
      face_d = FACE_NEG_Z;
    end else if (pos[1]) begin
      face_d = FACE_POS_Y;
      cv_d   = s1_comp_q[2];
      un_d   = 1'b1;
      vn_d   = 1'b1;
    end else if (neg[1]) begin
      face_d = FACE_NEG_Y;
      cv_d   = s1_comp_q[2];
    end else if (pos[0]) begin
      face_d = FACE_POS_X;
      cu_d   = s1_comp_q[2];
      un_d   = 1'b1;
      vn_d   = 1'b1;
    end else if (neg[0]) begin
      face_d = FACE_NEG_X;
      cu_d   = s1_comp_q[2];
    end else begin
      face_d = FACE_POS_X;
    end
  end

  logic                 s2_vld_q;
  logic                 s2_vres_q;
  face_e                s2_face_q;
  logic signed [CW-1:0] s2_cu_q, s2_cv_q;
  logic                 s2_un_q, s2_vn_q;
  logic [CW-1:0]        s2_a_q;

  always_ff @(posedge clk_i) begin
    s2_vres_q <= (s1_a_q != '0);
    s2_face_q <= face_d;
    s2_cu_q   <= cu_d;
    s2_cv_q   <= cv_d;
    s2_un_q   <= un_d;
    s2_vn_q   <= vn_d;
    s2_a_q    <= s1_a_q;
  end

  // ---------------------------------------------------------------------
  // Stage 3: numerators a -/+ c, edge wrap to zero, size saturation
  // ---------------------------------------------------------------------
  logic signed [CW+1:0] a_ext, nu_full, nv_full;
  logic [DW-1:0]        den_d;
  logic [DW-1:0]        nu_d, nv_d;
  logic [SATW-1:0]      w_ext, h_ext;
  logic [SW-1:0]        ws_d, hs_d;

  always_comb begin
    a_ext   = $signed({2'b00, s2_a_q});
    nu_full = s2_un_q ? (a_ext - (CW+2)'(s2_cu_q)) : (a_ext + (CW+2)'(s2_cu_q));
    nv_full = s2_vn_q ? (a_ext - (CW+2)'(s2_cv_q)) : (a_ext + (CW+2)'(s2_cv_q));
    den_d   = {s2_a_q, 1'b0};
    nu_d    = ((nu_full == '0) || (nu_full[DW-1:0] == den_d)) ? '0 : nu_full[DW-1:0];
    nv_d    = ((nv_full == '0) || (nv_full[DW-1:0] == den_d)) ? '0 : nv_full[DW-1:0];
    w_ext   = SATW'(width_q);
    h_ext   = SATW'(height_q);
    ws_d    = (w_ext > SATW'(MAX_FACE_SIZE)) ? SW'(MAX_FACE_SIZE) : w_ext[SW-1:0];
    hs_d    = (h_ext > SATW'(MAX_FACE_SIZE)) ? SW'(MAX_FACE_SIZE) : h_ext[SW-1:0];
  end

  logic          s3_vld_q;
  logic          s3_vres_q;
  face_e         s3_face_q;
  logic [DW-1:0] s3_nu_q, s3_nv_q, s3_den_q;
  logic [SW-1:0] s3_ws_q, s3_hs_q;

  always_ff @(posedge clk_i) begin
    s3_vres_q <= s2_vres_q;
    s3_face_q <= s2_face_q;
    s3_nu_q   <= nu_d;
    s3_nv_q   <= nv_d;
    s3_den_q  <= den_d;
    s3_ws_q   <= ws_d;
    s3_hs_q   <= hs_d;
  end

  // ---------------------------------------------------------------------
  // Stage 4: scale numerators by face size
  // ---------------------------------------------------------------------
  logic          s4_vld_q;
  side_t         s4_side_q;
  logic [NW-1:0] s4_numu_q, s4_numv_q;
  logic [DW-1:0] s4_den_q;

  always_ff @(posedge clk_i) begin
    s4_side_q <= '{vres: s3_vres_q, face: s3_face_q, ws: s3_ws_q};
    s4_numu_q <= NW'(s3_nu_q) * NW'(s3_ws_q);
    s4_numv_q <= NW'(s3_nv_q) * NW'(s3_hs_q);
    s4_den_q  <= s3_den_q;
  end

  // ---------------------------------------------------------------------
  // Divider stages: floor(n * size / 2a) for both coordinates
  // ---------------------------------------------------------------------
  logic [TW-1:0] quo_u, quo_v;

  cmfta_div #(
    .NUM_W (NW),
    .DEN_W (DW),
    .QUO_W (TW)
  ) u_div_u (
    .clk_i (clk_i),
    .num_i (s4_numu_q),
    .den_i (s4_den_q),
    .quo_o (quo_u)
  );

  cmfta_div #(
    .NUM_W (NW),
    .DEN_W (DW),
    .QUO_W (TW)
  ) u_div_v (
    .clk_i (clk_i),
    .num_i (s4_numv_q),
    .den_i (s4_den_q),
    .quo_o (quo_v)
  );

  // Carry face, validity and width alongside the divider
  logic  dv_vld_q  [TW];
  side_t dv_side_q [TW];

  for (genvar k = 0; k < TW; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_vld_q[k] <= 1'b0;
        end else begin
          dv_vld_q[k] <= s4_vld_q;
        end
      end
      always_ff @(posedge clk_i) begin
        dv_side_q[k] <= s4_side_q;
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_vld_q[k] <= 1'b0;
        end else begin
          dv_vld_q[k] <= dv_vld_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Front stage valid bits
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: linear index, zero vector forces zeros
  // ---------------------------------------------------------------------
  side_t         side_last;
  logic [XW-1:0] idx_full;

  always_comb begin
    side_last = dv_side_q[TW-1];
    idx_full  = XW'(quo_v) * XW'(side_last.ws) + XW'(quo_u);
  end

  logic          done_q;
  logic [FACE_W-1:0] face_q;
  logic [TW-1:0] tx_q, ty_q;
  logic [IW-1:0] idx_q;
  logic          vres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld_q[TW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    vres_q <= side_last.vres;
    face_q <= side_last.vres ? side_last.face : FACE_POS_X;
    tx_q   <= side_last.vres ? quo_u : '0;
    ty_q   <= side_last.vres ? quo_v : '0;
    idx_q  <= side_last.vres ? idx_full[IW-1:0] : '0;
  end

  assign done_o        = done_q;
  assign face_o        = face_q;
  assign texel_x_o     = tx_q;
  assign texel_y_o     = ty_q;
  assign texel_index_o = idx_q;
  assign valid_res_o   = vres_q;

endmodule

`default_nettype wire

FILE: rtl/cmfta_checker.sv
`default_nettype none
`include "cube_map_face_texel_address_defines.svh"

module cmfta_checker
  import cmfta_pkg::*;
#(
  parameter int MAX_FACE_SIZE = DEF_MAX_FACE_SIZE,
  localparam int TW = cmfta_tex_width(MAX_FACE_SIZE),
  localparam int IW = 2 * TW
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire logic [FACE_W-1:0] face_o,
  input wire logic [TW-1:0]     texel_x_o,
  input wire logic [TW-1:0]     texel_y_o,
  input wire logic [IW-1:0]     texel_index_o,
  input wire logic              valid_res_o
);

  localparam int LAT = cmfta_latency(MAX_FACE_SIZE);

  // Full rate: never hold off a transfer
  `CMFTA_ASSERT_ALWAYS(a_never_busy, !busy)

  // Every accepted item comes out after the fixed latency
  `CMFTA_ASSERT_IMPL(a_latency, start && !busy, ##LAT done_o)

  // No result without an item accepted the fixed latency earlier
  `CMFTA_ASSERT_IMPL(a_no_extra, done_o, $past(start && !busy, LAT))

  // Zero vector gives an all zero result
  `CMFTA_ASSERT_IMPL(a_zero_vec, done_o && !valid_res_o, (face_o == FACE_POS_X) && (texel_x_o == '0) && (texel_y_o == '0) && (texel_index_o == '0))

  // First row: index equals column; face code in range
  `CMFTA_ASSERT_IMPL(a_row0_index, done_o && (texel_y_o == '0), (texel_index_o == IW'(texel_x_o)) && (face_o <= FACE_NEG_Z))

endmodule

bind cube_map_face_texel_address cmfta_checker #(
  .MAX_FACE_SIZE (MAX_FACE_SIZE)
) u_cmfta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .face_o        (face_o),
  .texel_x_o     (texel_x_o),
  .texel_y_o     (texel_y_o),
  .texel_index_o (texel_index_o),
  .valid_res_o   (valid_res_o)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cmfta_pkg::*;

  localparam int MAX_SIZE = DEF_MAX_FACE_SIZE;
  localparam int CW       = DEF_COMPONENT_WIDTH;
  localparam int TXW      = cmfta_tex_width(MAX_SIZE);
  localparam int IXW      = 2 * TXW;
  localparam int LATENCY  = cmfta_latency(MAX_SIZE);

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [TXW-1:0]    tx;
    logic [TXW-1:0]    ty;
    logic [IXW-1:0]    idx;
    logic              valid;
  } texel_addr_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic signed [CW-1:0] dir_x_i = '0;
  logic signed [CW-1:0] dir_y_i = '0;
  logic signed [CW-1:0] dir_z_i = '0;
  logic              cfg_we_i    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i  = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              done_o;
  logic [FACE_W-1:0] face_o;
  logic [TXW-1:0]    texel_x_o;
  logic [TXW-1:0]    texel_y_o;
  logic [IXW-1:0]    texel_index_o;
  logic              valid_res_o;

  // Shadow copies of the size registers
  logic [CFG_W-1:0] face_w_reg = SIZE_RESET;
  logic [CFG_W-1:0] face_h_reg = SIZE_RESET;

  texel_addr_t pending_addr[$];
  int mismatch_count = 0;
  int gap_limit      = 18;

  cube_map_face_texel_address dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .face_o        (face_o),
    .texel_x_o     (texel_x_o),
    .texel_y_o     (texel_y_o),
    .texel_index_o (texel_index_o),
    .valid_res_o   (valid_res_o)
  );

  always #6 clk_i = ~clk_i;

  // Map one face coordinate to floor(u * size), with both edges wrapping to 0
  function automatic longint face_coord(longint c, bit flip, longint a, longint size);
    longint n;
    n = flip ? a - c : a + c;
    if (n <= 0 || n >= 2 * a) return 0;
    return (n * size) / (2 * a);
  endfunction

  // Work out face and texel address for one direction at the current sizes
  function automatic texel_addr_t predict_address(logic signed [CW-1:0] dx,
                                                  logic signed [CW-1:0] dy,
                                                  logic signed [CW-1:0] dz);
    longint comp[3];
    longint a, m, w, h, tx, ty;
    face_e f;
    int ui, vi;
    bit un, vn;
    texel_addr_t r;
    comp[0] = longint'(dx);
    comp[1] = longint'(dy);
    comp[2] = longint'(dz);
    a = 0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      m = (comp[i] < 0) ? -comp[i] : comp[i];
      if (m > a) a = m;
    end
    if (a == 0) return r;
    f  = FACE_POS_X;
    ui = 0; un = 1'b0;
    vi = 0; vn = 1'b0;
    // Later axes override earlier ones
    for (int i = 0; i < 3; i++) begin
      if (comp[i] * 1000 > a * 999) begin
        case (i)
          0: begin f = FACE_POS_X; ui = 2; un = 1'b1; vi = 1; vn = 1'b1; end
          1: begin f = FACE_POS_Y; ui = 0; un = 1'b1; vi = 2; vn = 1'b1; end
          default: begin f = FACE_POS_Z; ui = 0; un = 1'b0; vi = 1; vn = 1'b0; end
        endcase
      end
      if (comp[i] * 1000 < -(a * 999)) begin
        case (i)
          0: begin f = FACE_NEG_X; ui = 2; un = 1'b0; vi = 1; vn = 1'b0; end
          1: begin f = FACE_NEG_Y; ui = 0; un = 1'b0; vi = 2; vn = 1'b0; end
          default: begin f = FACE_NEG_Z; ui = 0; un = 1'b0; vi = 1; vn = 1'b0; end
        endcase
      end
    end
    w = (face_w_reg > CFG_W'(MAX_SIZE)) ? longint'(MAX_SIZE) : longint'(face_w_reg);
    h = (face_h_reg > CFG_W'(MAX_SIZE)) ? longint'(MAX_SIZE) : longint'(face_h_reg);
    tx = face_coord(comp[ui], un, a, w);
    ty = face_coord(comp[vi], vn, a, h);
    r.face  = f;
    r.tx    = tx[TXW-1:0];
    r.ty    = ty[TXW-1:0];
    r.idx   = IXW'(tx + ty * w);
    r.valid = 1'b1;
    return r;
  endfunction

  // Transfer one direction; returns at the accepting edge with start still high
  task automatic issue_dir(int x, int y, int z);
    int gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    dir_x_i <= x[CW-1:0];
    dir_y_i <= y[CW-1:0];
    dir_z_i <= z[CW-1:0];
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    pending_addr.push_back(predict_address(x[CW-1:0], y[CW-1:0], z[CW-1:0]));
  endtask

  // Drop start and wait until every result is back and the pipe is empty
  task automatic drain_pipe();
    start <= 1'b0;
    while (pending_addr.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Write both size registers while idle
  task automatic write_sizes(int w, int h);
    drain_pipe();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_FACE_WIDTH;
    cfg_wdata_i <= w[CFG_W-1:0];
    @(posedge clk_i);
    face_w_reg  = w[CFG_W-1:0];
    cfg_addr_i  <= CFG_FACE_HEIGHT;
    cfg_wdata_i <= h[CFG_W-1:0];
    @(posedge clk_i);
    face_h_reg  = h[CFG_W-1:0];
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int signed_in(int mag);
    return $urandom_range(0, 2 * mag) - mag;
  endfunction

  function automatic int rand_sign(int v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Draw one direction from a mix of shapes
  task automatic draw_dir(output int x, output int y, output int z);
    int v[3];
    int k, a, b, sh;
    k = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        v[0] = $urandom_range(0, 65535) - 32768;
        v[1] = $urandom_range(0, 65535) - 32768;
        v[2] = $urandom_range(0, 65535) - 32768;
      end
      3: begin
        v[0] = signed_in(4);
        v[1] = signed_in(4);
        v[2] = signed_in(4);
      end
      4: begin
        a = $urandom_range(1, 32767);
        v[k] = rand_sign(a);
        v[(k + 1) % 3] = signed_in(a);
        v[(k + 2) % 3] = signed_in(a);
      end
      5: begin
        // Second component right around the 0.999 ratio
        a = $urandom_range(1000, 32767);
        b = a - $urandom_range(0, a / 500 + 2);
        v[k] = rand_sign(a);
        v[(k + 1) % 3] = rand_sign(b);
        v[(k + 2) % 3] = signed_in(b);
      end
      6: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 4))
            0: v[i] = -32768;
            1: v[i] = 32767;
            2: v[i] = 0;
            3: v[i] = -1;
            default: v[i] = 1;
          endcase
        end
      end
      7: begin
        // Two equal magnitudes push a face coordinate onto the wrapping edge
        a = $urandom_range(1, 32767);
        v[k] = rand_sign(a);
        v[(k + 1) % 3] = rand_sign(a);
        v[(k + 2) % 3] = signed_in(a);
      end
      8: begin
        v[0] = 0;
        v[1] = 0;
        v[2] = 0;
        if ($urandom_range(0, 1)) v[k] = $urandom_range(0, 65535) - 32768;
      end
      default: begin
        sh = $urandom_range(0, 15);
        v[0] = ($urandom_range(0, 65535) - 32768) >>> sh;
        v[1] = ($urandom_range(0, 65535) - 32768) >>> sh;
        v[2] = ($urandom_range(0, 65535) - 32768) >>> sh;
      end
    endcase
    x = v[0];
    y = v[1];
    z = v[2];
  endtask

  task automatic issue_random(int count);
    int x, y, z;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 18;
      draw_dir(x, y, z);
      issue_dir(x, y, z);
    end
    gap_limit = 18;
  endtask

  // Axes, ties, threshold edges and wrapping coordinates at reset sizes
  task automatic test_face_selection();
    issue_dir(0, 0, 0);
    issue_dir(32767, 0, 0);
    issue_dir(-32768, 0, 0);
    issue_dir(0, 32767, 0);
    issue_dir(0, -32768, 0);
    issue_dir(0, 0, 32767);
    issue_dir(0, 0, -32768);
    issue_dir(1000, 999, 0);
    issue_dir(1000, 1000, 0);
    issue_dir(1000, -1000, 0);
    issue_dir(1000, 1000, 1000);
    issue_dir(-7, 7, -7);
    issue_dir(1000, 0, 1000);
    issue_dir(-1000, 0, 1000);
    issue_dir(1, 0, 0);
    issue_dir(-1, -1, -1);
    issue_dir(32767, -32768, 12345);
    issue_dir(-32768, -32768, -32768);
    issue_dir(1000, -999, -500);
    issue_dir(3, 1, -2);
    issue_dir(-20000, 19990, 5);
    issue_dir(12, -5, 7);
  endtask

  // Smallest, largest, saturating and zero sizes
  task automatic test_size_extremes();
    int sizes[7][2] = '{'{1, 1}, '{2048, 2048}, '{4095, 4095}, '{0, 0},
                        '{2047, 1}, '{1, 2048}, '{3, 4095}};
    foreach (sizes[i]) begin
      write_sizes(sizes[i][0], sizes[i][1]);
      issue_dir(32767, 0, 0);
      issue_dir(-1000, 0, 1000);
      issue_dir(1, -32768, 32767);
      issue_random(8);
    end
  endtask

  // Bulk random directions over a series of random sizes
  task automatic test_random_dirs();
    int w, h;
    for (int p = 0; p < 8; p++) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 2048);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 2048);
      write_sizes(w, h);
      issue_random(250);
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    texel_addr_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_addr.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: face=%0d x=%0d y=%0d idx=%0d valid=%0b",
                   face_o, texel_x_o, texel_y_o, texel_index_o, valid_res_o);
      end else begin
        exp_r = pending_addr.pop_front();
        if (exp_r.face !== face_o || exp_r.tx !== texel_x_o || exp_r.ty !== texel_y_o ||
            exp_r.idx !== texel_index_o || exp_r.valid !== valid_res_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp face=%0d x=%0d y=%0d idx=%0d valid=%0b, ",
                     exp_r.face, exp_r.tx, exp_r.ty, exp_r.idx, exp_r.valid,
                     "got face=%0d x=%0d y=%0d idx=%0d valid=%0b",
                     face_o, texel_x_o, texel_y_o, texel_index_o, valid_res_o);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_face_selection();
    test_size_extremes();
    test_random_dirs();
    drain_pipe();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_addr.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: cube_map_face_texel_address.f
+incdir+rtl
rtl/cmfta_pkg.sv
rtl/cmfta_div.sv
rtl/cube_map_face_texel_address.sv
rtl/cmfta_checker.sv
test/testbench.sv
